@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define XCR_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define XCR_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define XCR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/xcr_pkg.sv @@
// ----------------------------------------------------------------------------
// xcr_pkg
// shared constants and types of the xmodem checksum receiver
// ----------------------------------------------------------------------------
package xcr_pkg;

   localparam int BLOCK_BYTES = 128;
   localparam int OFFSET_W    = 24;

   // control characters
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;

   // result kinds
   localparam logic [1:0] KIND_CTRL   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   // finish status
   localparam logic [1:0] FIN_COMPLETE  = 2'd0;
   localparam logic [1:0] FIN_TIMEOUT   = 2'd1;
   localparam logic [1:0] FIN_CANCELLED = 2'd2;

   // configuration register indexes
   localparam logic [1:0] REG_HEADER_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_BYTE_TIMEOUT   = 2'd1;
   localparam logic [1:0] REG_RETRY_LIMIT    = 2'd2;

   typedef struct packed {
      logic [1:0]          kind;
      logic [7:0]          value;
      logic [OFFSET_W-1:0] offset;
      logic [OFFSET_W-1:0] length;
      logic [1:0]          status;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]         count;
      rsp_item_type [2:0] item;
   } rsp_bundle_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  index;
      logic [15:0] data;
   } csr_write_type;

endpackage

@@ sv/xmodem_checksum_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver_unit
// xmodem checksum receiver: start, byte and tick words in, control bytes,
// memory writes and session end out
// ----------------------------------------------------------------------------
// channel   dir   handshake               payload
// req       in    req_tvalid/req_tready   tuser cmd, tdata rx_byte
// rsp       out   rsp_tvalid/rsp_tready   tuser out_kind, tdata fields, tlast
// csr       in    csr_valid/csr_ready     csr_index, csr_data
//
// one input word per cycle while the result side is ready; a word passes an input
// register and the state logic, then 0 to 3 result words leave the result register,
// one a cycle while rsp_tready is high; the input side waits until the last is taken
// synchronous reset clears session state and loads the default timeouts
// rsp stalls back up into req through the result register and input register
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] byte_value, [31:8] write_offset,
                                    // [55:32] total_length, [57:56] finish_status
   output logic [1:0]  rsp_tuser,   // [1:0] out_kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import xcr_pkg::*;

   csr_write_type  csr_wr;
   rsp_bundle_type bundle;
   logic           bundle_valid;
   logic           bundle_ready;
   rsp_item_type   item;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   xcr_fsm u_fsm (
      .clock        (clock),
      .reset        (reset),
      .csr_wr       (csr_wr),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_cmd       (req_tuser),
      .in_byte      (req_tdata),
      .bundle_valid (bundle_valid),
      .bundle_ready (bundle_ready),
      .bundle       (bundle)
   );

   xcr_rsp_seq u_rsp_seq (
      .clock        (clock),
      .reset        (reset),
      .bundle_valid (bundle_valid),
      .bundle_ready (bundle_ready),
      .bundle       (bundle),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_item     (item),
      .out_last     (rsp_tlast)
   );

   assign rsp_tuser = item.kind;
   assign rsp_tdata = {6'd0, item.status, item.length, item.offset, item.value};

endmodule

@@ sv/xcr_fsm.sv @@
// ----------------------------------------------------------------------------
// xcr_fsm
// input register, protocol state and per-word result set generation
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xcr_fsm (
   input  logic                    clock,
   input  logic                    reset,
   input  xcr_pkg::csr_write_type  csr_wr,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [1:0]              in_cmd,
   input  logic [7:0]              in_byte,
   output logic                    bundle_valid,
   input  logic                    bundle_ready,
   output xcr_pkg::rsp_bundle_type bundle
);
   import xcr_pkg::*;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE, PH_HEADER, PH_BLKNUM, PH_BLKCOMP, PH_DATA, PH_CSUM
   } phase_type;

   function automatic rsp_item_type ctl_item(input logic [7:0] ch);
      rsp_item_type it;
      it       = '0;
      it.kind  = KIND_CTRL;
      it.value = ch;
      return it;
   endfunction

   function automatic rsp_item_type fin_item(input logic [OFFSET_W-1:0] len,
                                             input logic [1:0] st);
      rsp_item_type it;
      it        = '0;
      it.kind   = KIND_FINISH;
      it.length = len;
      it.status = st;
      return it;
   endfunction

   logic [15:0]         hdr_to_ff, byte_to_ff;
   logic [7:0]          retry_limit_ff;
   logic                in_valid_ff;
   logic [1:0]          in_cmd_ff;
   logic [7:0]          in_byte_ff;

   phase_type           phase_ff, phase_in;
   logic [7:0]          expected_ff, expected_in;
   logic [7:0]          retry_ff, retry_in;
   logic [OFFSET_W-1:0] length_ff, length_in;
   logic [7:0]          index_ff, index_in;
   logic [7:0]          sum_ff, sum_in;
   logic [7:0]          got_num_ff, got_num_in;
   logic                hdr_bad_ff, hdr_bad_in;
   logic [15:0]         wait_ff, wait_in;

   logic                fire;
   logic [15:0]         wait_sat;
   logic [7:0]          retry_bump;
   logic [7:0]          index_inc;
   rsp_bundle_type      res;

   assign fire         = in_valid_ff && bundle_ready;
   assign in_ready     = !in_valid_ff || bundle_ready;
   assign bundle_valid = fire && (res.count != 2'd0);
   assign bundle       = res;

   assign wait_sat   = (wait_ff == 16'hFFFF) ? wait_ff : wait_ff + 16'd1;
   assign retry_bump = (retry_ff == 8'hFF) ? retry_ff : retry_ff + 8'd1;
   assign index_inc  = index_ff + 8'd1;

   always_comb begin
      phase_in    = phase_ff;
      expected_in = expected_ff;
      retry_in    = retry_ff;
      length_in   = length_ff;
      index_in    = index_ff;
      sum_in      = sum_ff;
      got_num_in  = got_num_ff;
      hdr_bad_in  = hdr_bad_ff;
      wait_in     = wait_ff;
      res         = '0;
      if (in_cmd_ff == CMD_START) begin
         expected_in = 8'd1;
         retry_in    = '0;
         length_in   = '0;
         index_in    = '0;
         sum_in      = '0;
         got_num_in  = '0;
         hdr_bad_in  = 1'b0;
         phase_in    = PH_HEADER;
         wait_in     = '0;
         res.item[0] = ctl_item(CH_NAK);
         res.count   = 2'd1;
      end else if (in_cmd_ff == CMD_TICK && phase_ff != PH_IDLE) begin
         wait_in = wait_sat;
         if (phase_ff == PH_HEADER) begin
            if (wait_sat >= hdr_to_ff) begin
               wait_in  = '0;
               retry_in = retry_bump;
               if (retry_bump > retry_limit_ff) begin
                  res.item[0] = ctl_item(CH_CAN);
                  res.item[1] = ctl_item(CH_CAN);
                  res.item[2] = fin_item('0, FIN_TIMEOUT);
                  res.count   = 2'd3;
                  phase_in    = PH_IDLE;
               end else begin
                  res.item[0] = ctl_item(CH_NAK);
                  res.count   = 2'd1;
               end
            end
         end else if (wait_sat >= byte_to_ff) begin
            res.item[0] = ctl_item(CH_NAK);
            res.count   = 2'd1;
            phase_in    = PH_HEADER;
            wait_in     = '0;
         end
      end else if (in_cmd_ff == CMD_BYTE && phase_ff != PH_IDLE) begin
         wait_in = '0;
         case (phase_ff)
            PH_HEADER: begin
               if (in_byte_ff == CH_EOT) begin
                  res.item[0] = ctl_item(CH_ACK);
                  res.item[1] = fin_item(length_ff, FIN_COMPLETE);
                  res.count   = 2'd2;
                  phase_in    = PH_IDLE;
               end else if (in_byte_ff == CH_CAN) begin
                  res.item[0] = fin_item('0, FIN_CANCELLED);
                  res.count   = 2'd1;
                  phase_in    = PH_IDLE;
               end else if (in_byte_ff == CH_SOH) begin
                  hdr_bad_in = 1'b0;
                  sum_in     = '0;
                  index_in   = '0;
                  phase_in   = PH_BLKNUM;
               end
            end
            PH_BLKNUM: begin
               got_num_in = in_byte_ff;
               phase_in   = PH_BLKCOMP;
            end
            PH_BLKCOMP: begin
               hdr_bad_in = (got_num_ff != expected_ff) || (in_byte_ff != ~expected_ff);
               phase_in   = PH_DATA;
            end
            PH_DATA: begin
               res.item[0].kind   = KIND_WRITE;
               res.item[0].value  = in_byte_ff;
               res.item[0].offset = length_ff + {{(OFFSET_W-8){1'b0}}, index_ff};
               res.count          = 2'd1;
               sum_in             = sum_ff + in_byte_ff;
               index_in           = index_inc;
               if (index_inc >= 8'(BLOCK_BYTES)) begin
                  phase_in = PH_CSUM;
               end
            end
            PH_CSUM: begin
               if (hdr_bad_ff || in_byte_ff != sum_ff) begin
                  retry_in    = retry_bump;
                  res.item[0] = ctl_item(CH_NAK);
               end else begin
                  retry_in    = '0;
                  length_in   = length_ff + OFFSET_W'(BLOCK_BYTES);
                  expected_in = expected_ff + 8'd1;
                  res.item[0] = ctl_item(CH_ACK);
               end
               res.count = 2'd1;
               phase_in  = PH_HEADER;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_to_ff      <= 16'd3000;
         byte_to_ff     <= 16'd1000;
         retry_limit_ff <= 8'd20;
         in_valid_ff    <= 1'b0;
         phase_ff       <= PH_IDLE;
         expected_ff    <= 8'd1;
         retry_ff       <= '0;
         length_ff      <= '0;
         index_ff       <= '0;
         sum_ff         <= '0;
         got_num_ff     <= '0;
         hdr_bad_ff     <= 1'b0;
         wait_ff        <= '0;
      end else begin
         if (csr_wr.valid) begin
            case (csr_wr.index)
               REG_HEADER_TIMEOUT: hdr_to_ff      <= csr_wr.data;
               REG_BYTE_TIMEOUT:   byte_to_ff     <= csr_wr.data;
               REG_RETRY_LIMIT:    retry_limit_ff <= csr_wr.data[7:0];
               default: ;
            endcase
         end
         if (in_ready) begin
            in_valid_ff <= in_valid;
         end
         if (fire) begin
            phase_ff    <= phase_in;
            expected_ff <= expected_in;
            retry_ff    <= retry_in;
            length_ff   <= length_in;
            index_ff    <= index_in;
            sum_ff      <= sum_in;
            got_num_ff  <= got_num_in;
            hdr_bad_ff  <= hdr_bad_in;
            wait_ff     <= wait_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         in_cmd_ff  <= in_cmd;
         in_byte_ff <= in_byte;
      end
   end

   `XCR_ASSERT_ALWAYS(a_index_range, index_ff <= 8'(BLOCK_BYTES), "data index past block size")
   `XCR_ASSERT_IMPLY(a_data_index, phase_ff == PH_DATA, index_ff < 8'(BLOCK_BYTES), "data phase with full block")
   `XCR_ASSERT_NEXT(a_fin_idle, fire && res.count == 2'd3, phase_ff == PH_IDLE, "timeout finish left session open")

endmodule

@@ sv/xcr_rsp_seq.sv @@
// ----------------------------------------------------------------------------
// xcr_rsp_seq
// result register holding one result set, sent out one word at a time
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xcr_rsp_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    bundle_valid,
   output logic                    bundle_ready,
   input  xcr_pkg::rsp_bundle_type bundle,
   output logic                    out_valid,
   input  logic                    out_ready,
   output xcr_pkg::rsp_item_type   out_item,
   output logic                    out_last
);
   import xcr_pkg::*;

   rsp_bundle_type bundle_ff;
   logic           valid_ff;
   logic [1:0]     idx_ff;
   logic           taken;

   assign out_valid    = valid_ff;
   assign out_last     = (idx_ff == bundle_ff.count - 2'd1);
   assign taken        = valid_ff && out_ready;
   assign bundle_ready = !valid_ff || (out_ready && out_last);

   always_comb begin
      case (idx_ff)
         2'd0:    out_item = bundle_ff.item[0];
         2'd1:    out_item = bundle_ff.item[1];
         2'd2:    out_item = bundle_ff.item[2];
         default: out_item = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (bundle_ready && bundle_valid) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (taken && out_last) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (taken) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (bundle_ready && bundle_valid) begin
         bundle_ff <= bundle;
      end
   end

   `XCR_ASSERT_IMPLY(a_idx_in_set, valid_ff, idx_ff < bundle_ff.count, "word index past result count")
   `XCR_ASSERT_NEXT(a_hold_set, valid_ff && !out_ready, valid_ff && $stable(idx_ff), "stalled result set moved")

endmodule

@@ test/xcr_checker.sv @@
// ----------------------------------------------------------------------------
// xcr_checker
// watches the request, result and register channels of the xmodem receiver,
// keeps its own copy of the session state and settings, predicts the result
// words of every accepted request word and compares them in order
// ----------------------------------------------------------------------------
package xcr_tb_pkg;

   typedef enum logic [1:0] {
      CMD_START    = 2'd0,
      CMD_BYTE     = 2'd1,
      CMD_TICK     = 2'd2,
      CMD_RESERVED = 2'd3
   } cmd_type;

endpackage

module xcr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);

   import xcr_pkg::*;
   import xcr_tb_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE, PH_HEADER, PH_BLKNUM, PH_BLKCOMP, PH_DATA, PH_CSUM
   } rx_phase_type;

   typedef struct packed {
      rsp_item_type item;
      logic         last;
   } reply_type;

   rx_phase_type phase;
   logic [7:0]   blk_want;
   logic [7:0]   blk_got;
   logic [7:0]   retries;
   logic [23:0]  length;
   logic [7:0]   data_idx;
   logic [7:0]   csum;
   logic         bad_hdr;
   logic [15:0]  ticks;
   logic [15:0]  hdr_limit;
   logic [15:0]  byte_limit;
   logic [7:0]   retry_max;

   reply_type reply_q[$];
   reply_type want;
   int        mismatches = 0;

   function automatic void add_reply(input logic [1:0] kind, input logic [7:0] val,
                                     input logic [23:0] off, input logic [23:0] len,
                                     input logic [1:0] st);
      reply_type r;
      r.item.kind   = kind;
      r.item.value  = val;
      r.item.offset = off;
      r.item.length = len;
      r.item.status = st;
      r.last        = 1'b0;
      reply_q.push_back(r);
   endfunction

   function automatic void predict_xmodem_reply(input cmd_type cmd, input logic [7:0] b);
      int first;
      first = reply_q.size();
      if (cmd == CMD_START) begin
         blk_want = 8'd1;
         retries  = '0;
         length   = '0;
         data_idx = '0;
         csum     = '0;
         blk_got  = '0;
         bad_hdr  = 1'b0;
         phase    = PH_HEADER;
         ticks    = '0;
         add_reply(KIND_CTRL, CH_NAK, '0, '0, '0);
      end else if (cmd == CMD_RESERVED || phase == PH_IDLE) begin
      end else if (cmd == CMD_TICK) begin
         if (ticks != 16'hFFFF)
            ticks = ticks + 16'd1;
         if (phase == PH_HEADER) begin
            if (ticks >= hdr_limit) begin
               ticks = '0;
               if (retries != 8'hFF)
                  retries = retries + 8'd1;
               if (retries > retry_max) begin
                  add_reply(KIND_CTRL, CH_CAN, '0, '0, '0);
                  add_reply(KIND_CTRL, CH_CAN, '0, '0, '0);
                  add_reply(KIND_FINISH, '0, '0, '0, FIN_TIMEOUT);
                  phase = PH_IDLE;
               end else begin
                  add_reply(KIND_CTRL, CH_NAK, '0, '0, '0);
               end
            end
         end else if (ticks >= byte_limit) begin
            add_reply(KIND_CTRL, CH_NAK, '0, '0, '0);
            phase = PH_HEADER;
            ticks = '0;
         end
      end else begin
         ticks = '0;
         case (phase)
            PH_HEADER: begin
               if (b == CH_EOT) begin
                  add_reply(KIND_CTRL, CH_ACK, '0, '0, '0);
                  add_reply(KIND_FINISH, '0, '0, length, FIN_COMPLETE);
                  phase = PH_IDLE;
               end else if (b == CH_CAN) begin
                  add_reply(KIND_FINISH, '0, '0, '0, FIN_CANCELLED);
                  phase = PH_IDLE;
               end else if (b == CH_SOH) begin
                  bad_hdr  = 1'b0;
                  csum     = '0;
                  data_idx = '0;
                  phase    = PH_BLKNUM;
               end
            end
            PH_BLKNUM: begin
               blk_got = b;
               phase   = PH_BLKCOMP;
            end
            PH_BLKCOMP: begin
               bad_hdr = (blk_got != blk_want) || (b != ~blk_want);
               phase   = PH_DATA;
            end
            PH_DATA: begin
               add_reply(KIND_WRITE, b, length + {16'h0000, data_idx}, '0, '0);
               csum     = csum + b;
               data_idx = data_idx + 8'd1;
               if (data_idx >= BLOCK_BYTES)
                  phase = PH_CSUM;
            end
            default: begin
               if (bad_hdr || b != csum) begin
                  if (retries != 8'hFF)
                     retries = retries + 8'd1;
                  add_reply(KIND_CTRL, CH_NAK, '0, '0, '0);
               end else begin
                  retries  = '0;
                  length   = length + 24'(BLOCK_BYTES);
                  blk_want = blk_want + 8'd1;
                  add_reply(KIND_CTRL, CH_ACK, '0, '0, '0);
               end
               phase = PH_HEADER;
               ticks = '0;
            end
         endcase
      end
      if (reply_q.size() > first)
         reply_q[reply_q.size() - 1].last = 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         phase      = PH_IDLE;
         blk_want   = 8'd1;
         blk_got    = '0;
         retries    = '0;
         length     = '0;
         data_idx   = '0;
         csum       = '0;
         bad_hdr    = 1'b0;
         ticks      = '0;
         hdr_limit  = 16'd3000;
         byte_limit = 16'd1000;
         retry_max  = 8'd20;
         reply_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_HEADER_TIMEOUT: hdr_limit  = csr_data;
               REG_BYTE_TIMEOUT:   byte_limit = csr_data;
               REG_RETRY_LIMIT:    retry_max  = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_xmodem_reply(cmd_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               $error("result word with nothing expected: kind %0d, tdata 0x%0h",
                      rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = reply_q.pop_front();
               check_field("out_kind", 32'(want.item.kind), 32'(rsp_tuser));
               check_field("byte_value", 32'(want.item.value), 32'(rsp_tdata[7:0]));
               check_field("write_offset", 32'(want.item.offset), 32'(rsp_tdata[31:8]));
               check_field("total_length", 32'(want.item.length), 32'(rsp_tdata[55:32]));
               check_field("finish_status", 32'(want.item.status),
                           32'(rsp_tdata[57:56]));
               check_field("last", 32'(want.last), 32'(rsp_tlast));
            end
         end
      end
      fail_count <= mismatches;
      pending    <= reply_q.size();
   end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// drives the xmodem receiver with start, byte and tick words: a short directed
// run through the special cases, one full block transfer, then short sessions
// under several timeout settings, with random gaps on both sides;
// the checker beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_top;

   import xcr_pkg::*;
   import xcr_tb_pkg::*;

   localparam int ITEM_TARGET = 230;

   typedef enum int {
      BLK_GOOD, BLK_BAD_NUMBER, BLK_BAD_COMPLEMENT, BLK_BAD_SUM, BLK_STALLED
   } flaw_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid  = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;

   logic        req_tready;
   logic        rsp_tvalid;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_ready;

   int          fail_count;
   int          pending;
   int          quiet_cycles = 0;
   int          sent_items   = 0;
   bit          send_rush    = 1'b0;
   bit          recv_rush    = 1'b0;
   logic [15:0] cur_byte_to  = 16'd1000;
   logic [7:0]  next_blk     = 8'd1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   xmodem_checksum_receiver_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   xcr_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 1000) begin
         $display("watchdog: no word moved for %0d cycles", quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int stall;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0)
            recv_rush = !recv_rush;
         stall = recv_rush ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (rsp_tvalid !== 1'b1);
         @(posedge clock);
      end
   end

   task automatic send_word(input cmd_type c, input logic [7:0] b);
      int gap;
      if ($urandom_range(0, 29) == 0)
         send_rush = !send_rush;
      gap = send_rush ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= b;
      do @(negedge clock); while (req_tready !== 1'b1);
      @(posedge clock);
      if (c != CMD_RESERVED)
         sent_items++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(negedge clock); while (csr_ready !== 1'b1);
      @(posedge clock);
   endtask

   task automatic set_timeouts(input logic [15:0] hdr_to, input logic [15:0] byte_to,
                               input logic [7:0] retry_lim);
      settle();
      write_csr(REG_HEADER_TIMEOUT, hdr_to);
      write_csr(REG_BYTE_TIMEOUT, byte_to);
      write_csr(REG_RETRY_LIMIT, {8'($urandom), retry_lim});
      csr_valid <= 1'b0;
      cur_byte_to = byte_to;
   endtask

   task automatic send_block(input flaw_type flaw);
      logic [7:0] num;
      logic [7:0] comp;
      logic [7:0] sum;
      logic [7:0] d;
      int         cut;
      num  = (flaw == BLK_BAD_NUMBER) ? next_blk + 8'($urandom_range(1, 255)) : next_blk;
      comp = (flaw == BLK_BAD_COMPLEMENT) ? ~next_blk ^ 8'($urandom_range(1, 255))
                                          : ~next_blk;
      cut  = (flaw == BLK_STALLED) ? $urandom_range(0, BLOCK_BYTES - 1) : BLOCK_BYTES;
      sum  = '0;
      send_word(CMD_BYTE, CH_SOH);
      send_word(CMD_BYTE, num);
      send_word(CMD_BYTE, comp);
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         if (i == cut) begin
            // sender goes quiet mid block, or gives up when the timeout is out of reach
            if (cur_byte_to <= 16'd8) begin
               repeat ((cur_byte_to == 0) ? 1 : int'(cur_byte_to))
                  send_word(CMD_TICK, 8'($urandom));
            end else begin
               send_word(CMD_START, 8'($urandom));
               next_blk = 8'd1;
            end
            return;
         end
         if ($urandom_range(0, 7) == 0)
            d = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else
            d = 8'($urandom);
         sum = sum + d;
         if (cur_byte_to >= 16'd2 && $urandom_range(0, 15) == 0)
            send_word(CMD_TICK, 8'($urandom));
         send_word(CMD_BYTE, d);
      end
      send_word(CMD_BYTE, (flaw == BLK_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum);
      if (flaw == BLK_GOOD)
         next_blk = next_blk + 8'd1;
   endtask

   task automatic run_session();
      int         acts;
      int         pick;
      logic [7:0] b;
      send_word(CMD_START, 8'($urandom));
      next_blk = 8'd1;
      acts = $urandom_range(0, 3);
      repeat (acts) begin
         pick = $urandom_range(0, 9);
         // whole blocks only while the run has room for one
         if ((pick <= 2 || pick == 9) && sent_items + BLOCK_BYTES + 8 > ITEM_TARGET)
            pick = 5;
         if (pick <= 2) begin
            if ($urandom_range(0, 2) != 0)
               send_block(BLK_GOOD);
            else
               send_block(flaw_type'($urandom_range(1, 4)));
         end else if (pick <= 4) begin
            do b = 8'($urandom); while (b == CH_SOH || b == CH_EOT || b == CH_CAN);
            send_word(CMD_BYTE, b);
         end else if (pick <= 6) begin
            repeat ($urandom_range(1, 6)) send_word(CMD_TICK, 8'($urandom));
         end else if (pick == 7) begin
            send_word(CMD_RESERVED, 8'($urandom));
         end else if (pick == 8) begin
            send_word(CMD_START, 8'($urandom));
            next_blk = 8'd1;
         end else begin
            send_block(BLK_GOOD);
         end
      end
      pick = $urandom_range(0, 3);
      if (pick <= 1)
         send_word(CMD_BYTE, CH_EOT);
      else if (pick == 2)
         send_word(CMD_BYTE, CH_CAN);
   endtask

   task automatic run_phase(input logic [15:0] hdr_to, input logic [15:0] byte_to,
                            input logic [7:0] retry_lim, input int budget);
      int mark;
      set_timeouts(hdr_to, byte_to, retry_lim);
      mark = sent_items;
      while (sent_items - mark < budget)
         run_session();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // nothing happens before a start, then sessions ended by EOT and by CAN
      send_word(CMD_BYTE, CH_SOH);
      send_word(CMD_TICK, 8'hFF);
      send_word(CMD_RESERVED, 8'hFF);
      send_word(CMD_START, 8'h00);
      send_word(CMD_BYTE, 8'h00);
      send_word(CMD_BYTE, 8'hFF);
      send_word(CMD_BYTE, CH_EOT);
      send_word(CMD_START, 8'hA5);
      send_word(CMD_BYTE, CH_CAN);

      // header timeouts up to failure, then in-block timeouts and restart
      set_timeouts(16'd2, 16'd1, 8'd1);
      send_word(CMD_START, 8'h00);
      repeat (4) send_word(CMD_TICK, 8'h00);
      send_word(CMD_TICK, 8'h5A);
      send_word(CMD_START, 8'h00);
      send_word(CMD_BYTE, CH_SOH);
      send_word(CMD_TICK, 8'h00);
      send_word(CMD_BYTE, CH_SOH);
      send_word(CMD_BYTE, 8'h01);
      send_word(CMD_TICK, 8'h00);
      send_word(CMD_START, 8'h00);
      send_word(CMD_BYTE, CH_CAN);

      // full transfer with no timeouts in reach, one good or flawed block
      set_timeouts(16'hFFFF, 16'hFFFF, 8'($urandom));
      send_word(CMD_START, 8'h00);
      next_blk = 8'd1;
      send_block(($urandom_range(0, 1) == 0) ? BLK_GOOD
                                             : flaw_type'($urandom_range(1, 3)));
      send_word(CMD_BYTE, CH_EOT);

      run_phase(16'd1, 16'd1, 8'd0, 15);

      // retry limit at its top, a header timeout on every tick
      set_timeouts(16'd0, 16'd0, 8'hFF);
      send_word(CMD_START, 8'h00);
      repeat (6) send_word(CMD_TICK, 8'($urandom));
      send_word(CMD_BYTE, CH_EOT);
      run_phase(16'd0, 16'd0, 8'hFF, 15);

      run_phase(16'hFFFF, 16'hFFFF, 8'($urandom), 10);
      run_phase(($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 8)),
                ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 8)),
                8'($urandom_range(0, 3)), 15);

      settle();
      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
